// ===== hw/rtl/tep_pkg.sv =====
// Shared constants and types for the time-over-threshold edge pairing block.
package tep_pkg;

  localparam int CHANNEL_COUNT = 32;
  localparam int TIME_BITS     = 48;
  localparam int TAG_BITS      = 20;
  localparam int CHAN_BITS     = 5;
  localparam int TDC_BITS      = 2;
  localparam int RUN_BITS      = 8;
  localparam int SPILL_BITS    = 16;
  localparam int GROUP_BITS    = RUN_BITS + SPILL_BITS;
  localparam int DUR_BITS      = 24;
  localparam int SLOTS         = 2 * CHANNEL_COUNT;
  localparam int SLOT_BITS     = $clog2(SLOTS);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam int TDC_EDGE_BIT = 0;
  localparam int TDC_PAIR_BIT = 1;

  localparam int          ADDR_BITS          = 3;
  localparam int          DATA_BITS          = 32;
  localparam logic        REG_MAX_DURATION   = 1'b0;
  localparam logic [DUR_BITS-1:0] MAX_DURATION_RESET = DUR_BITS'(20480);

  typedef struct packed {
    logic [TIME_BITS-1:0]  lead_time;
    logic [TAG_BITS-1:0]   lead_tag;
    logic [GROUP_BITS-1:0] group;
  } entry_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] channel;
    logic                 pair;
    logic [TAG_BITS-1:0]  lead_tag;
    logic [TAG_BITS-1:0]  trail_tag;
    logic [TIME_BITS-1:0] lead_time;
    logic [TIME_BITS-1:0] trail_time;
  } cand_t;

  typedef struct packed {
    logic push;
  } qctl_t;

endpackage

// ===== hw/rtl/tep_front.sv =====
// Front end: accepts hits, keeps the leading-edge table and emits pair candidates.
module tep_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tep_pkg::CHAN_BITS-1:0]   channel,
  input  logic [tep_pkg::TDC_BITS-1:0]    tdc,
  input  logic [tep_pkg::RUN_BITS-1:0]    run_tag,
  input  logic [tep_pkg::SPILL_BITS-1:0]  spill_tag,
  input  logic [tep_pkg::TIME_BITS-1:0]   hit_time,
  input  logic [tep_pkg::TAG_BITS-1:0]    hit_tag,
  input  logic                            q_full,
  output tep_pkg::qctl_t                  qctl,
  output tep_pkg::cand_t                  cand
);

  tep_pkg::entry_t                    mem [tep_pkg::SLOTS];
  logic [tep_pkg::SLOTS-1:0]          lvalid;
  tep_pkg::entry_t                    rd_entry;
  tep_pkg::entry_t                    byp_entry;
  logic                               byp_hit;

  logic                               s1_valid;
  logic                               s1_ok;
  logic [tep_pkg::SLOT_BITS-1:0]      s1_slot;
  logic [tep_pkg::CHAN_BITS-1:0]      s1_channel;
  logic                               s1_trail;
  logic [tep_pkg::GROUP_BITS-1:0]     s1_group;
  logic [tep_pkg::TIME_BITS-1:0]      s1_time;
  logic [tep_pkg::TAG_BITS-1:0]       s1_tag;

  logic [tep_pkg::SLOT_BITS-1:0]      in_slot;
  logic                               in_ok;
  logic                               in_take;
  logic                               s1_go;
  logic                               s1_cand;
  logic                               wr_en;
  tep_pkg::entry_t                    stored;
  tep_pkg::entry_t                    wr_entry;

  always_comb begin
    in_slot  = tep_pkg::SLOT_BITS'({channel, tdc[tep_pkg::TDC_PAIR_BIT]});
    in_ok    = (int'(channel) < tep_pkg::CHANNEL_COUNT);
    stored   = byp_hit ? byp_entry : rd_entry;
    s1_cand  = s1_valid && s1_ok && s1_trail && lvalid[s1_slot] &&
               (stored.group == s1_group);
    s1_go    = s1_valid && !(s1_cand && q_full);
    in_stall = s1_valid && !s1_go;
    in_take  = in_valid && !in_stall;
    wr_en    = s1_go && s1_ok && !s1_trail;
    wr_entry.lead_time = s1_time;
    wr_entry.lead_tag  = s1_tag;
    wr_entry.group     = s1_group;

    qctl.push       = s1_go && s1_cand;
    cand.channel    = s1_channel;
    cand.pair       = s1_slot[0];
    cand.lead_tag   = stored.lead_tag;
    cand.trail_tag  = s1_tag;
    cand.lead_time  = stored.lead_time;
    cand.trail_time = s1_time;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_slot] <= wr_entry;
    end
    if (in_take) begin
      rd_entry  <= mem[in_slot];
      byp_hit   <= wr_en && (s1_slot == in_slot);
      byp_entry <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ok      <= in_ok;
      s1_slot    <= in_slot;
      s1_channel <= channel;
      s1_trail   <= tdc[tep_pkg::TDC_EDGE_BIT];
      s1_group   <= {run_tag, spill_tag};
      s1_time    <= hit_time;
      s1_tag     <= hit_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lvalid   <= '0;
    end else begin
      s1_valid <= in_take || (s1_valid && !s1_go);
      if (wr_en) begin
        lvalid[s1_slot] <= 1'b1;
      end else if (qctl.push) begin
        lvalid[s1_slot] <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/tep_queue.sv =====
// Short candidate queue between the front end and the back end.
module tep_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tep_pkg::cand_t  wr_data,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output tep_pkg::cand_t  head
);

  tep_pkg::cand_t                  buf_q [tep_pkg::QUEUE_DEPTH];
  logic [tep_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [tep_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [tep_pkg::QPTR_BITS:0]     count;

  always_comb begin
    full     = (count == (tep_pkg::QPTR_BITS+1)'(tep_pkg::QUEUE_DEPTH));
    nonempty = (count != '0);
    head     = buf_q[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      buf_q[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && nonempty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && nonempty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tep_back.sv =====
// Back end: checks the duration of each candidate and holds the output register.
module tep_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_nonempty,
  input  tep_pkg::cand_t                 head,
  output logic                           pop,
  input  logic [tep_pkg::DUR_BITS-1:0]   max_duration,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tep_pkg::CHAN_BITS-1:0]  out_channel,
  output logic                           out_pair,
  output logic [tep_pkg::TAG_BITS-1:0]   leading_tag,
  output logic [tep_pkg::TAG_BITS-1:0]   trailing_tag,
  output logic [tep_pkg::TIME_BITS-1:0]  leading_time,
  output logic [tep_pkg::DUR_BITS-1:0]   time_over_threshold
);

  logic [tep_pkg::TIME_BITS-1:0] dt;
  logic                          good;
  logic                          advance;

  always_comb begin
    dt      = head.trail_time - head.lead_time;
    good    = (head.trail_time > head.lead_time) &&
              (dt <= {{(tep_pkg::TIME_BITS-tep_pkg::DUR_BITS){1'b0}}, max_duration});
    advance = !out_valid || !out_stall;
    pop     = q_nonempty && advance;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel         <= head.channel;
      out_pair            <= head.pair;
      leading_tag         <= head.lead_tag;
      trailing_tag        <= head.trail_tag;
      leading_time        <= head.lead_time;
      time_over_threshold <= dt[tep_pkg::DUR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pop && good;
    end
  end

endmodule

// ===== hw/rtl/tot_edge_pairing.sv =====
// Time-over-threshold edge pairing top level with configuration register.
// Path: table read-modify-write stage, four-entry candidate queue, output register.
// Throughput: one hit per cycle unless a full queue stalls the input; the table stage and
// duration check each handle one transaction per cycle, decoupled by the queue.
// Reset: clears the leading-edge valid bits, queue and pipeline, and sets
// max_duration to 20480; no clearing pass is needed.
module tot_edge_pairing (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tep_pkg::CHAN_BITS-1:0]     channel,
  input  logic [tep_pkg::TDC_BITS-1:0]      tdc,
  input  logic [tep_pkg::RUN_BITS-1:0]      run_tag,
  input  logic [tep_pkg::SPILL_BITS-1:0]    spill_tag,
  input  logic [tep_pkg::TIME_BITS-1:0]     hit_time,
  input  logic [tep_pkg::TAG_BITS-1:0]      hit_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tep_pkg::CHAN_BITS-1:0]     out_channel,
  output logic                              out_pair,
  output logic [tep_pkg::TAG_BITS-1:0]      leading_tag,
  output logic [tep_pkg::TAG_BITS-1:0]      trailing_tag,
  output logic [tep_pkg::TIME_BITS-1:0]     leading_time,
  output logic [tep_pkg::DUR_BITS-1:0]      time_over_threshold,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tep_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [tep_pkg::DATA_BITS-1:0]     pwdata,
  output logic [tep_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);

  logic [tep_pkg::DUR_BITS-1:0] max_duration;
  logic                         reg_sel;
  tep_pkg::qctl_t               qctl;
  tep_pkg::cand_t               cand;
  tep_pkg::cand_t               head;
  logic                         q_full;
  logic                         q_nonempty;
  logic                         pop;

  always_comb begin
    pready  = 1'b1;
    reg_sel = (paddr[tep_pkg::ADDR_BITS-1] == tep_pkg::REG_MAX_DURATION);
    prdata  = reg_sel ? tep_pkg::DATA_BITS'(max_duration) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duration <= tep_pkg::MAX_DURATION_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_duration <= pwdata[tep_pkg::DUR_BITS-1:0];
    end
  end

  tep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .channel   (channel),
    .tdc       (tdc),
    .run_tag   (run_tag),
    .spill_tag (spill_tag),
    .hit_time  (hit_time),
    .hit_tag   (hit_tag),
    .q_full    (q_full),
    .qctl      (qctl),
    .cand      (cand)
  );

  tep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (qctl.push),
    .wr_data  (cand),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (head)
  );

  tep_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_nonempty          (q_nonempty),
    .head                (head),
    .pop                 (pop),
    .max_duration        (max_duration),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel         (out_channel),
    .out_pair            (out_pair),
    .leading_tag         (leading_tag),
    .trailing_tag        (trailing_tag),
    .leading_time        (leading_time),
    .time_over_threshold (time_over_threshold)
  );

endmodule

// ===== test/tot_edge_pairing_tb.sv =====
// Self-checking testbench for tot_edge_pairing: directed and random hits against a pairing model.
`timescale 1ns / 1ps

module testbench;

  localparam logic [tep_pkg::ADDR_BITS-1:0] MAX_DUR_ADDR =
      tep_pkg::ADDR_BITS'(4 * int'(tep_pkg::REG_MAX_DURATION));
  localparam logic [tep_pkg::ADDR_BITS-1:0] SPARE_ADDR   = tep_pkg::ADDR_BITS'(4);
  localparam logic [tep_pkg::TDC_BITS-1:0]  TDC_LEAD0    = 2'b00;
  localparam logic [tep_pkg::TDC_BITS-1:0]  TDC_TRAIL0   = 2'b01;
  localparam logic [tep_pkg::TDC_BITS-1:0]  TDC_LEAD1    = 2'b10;
  localparam logic [tep_pkg::TDC_BITS-1:0]  TDC_TRAIL1   = 2'b11;
  localparam int unsigned                   RUN_LIMIT    = 500000;
  localparam int                            PHASE_HITS   = 260;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct packed {
    logic [tep_pkg::CHAN_BITS-1:0]  ch;
    logic [tep_pkg::TDC_BITS-1:0]   code;
    logic [tep_pkg::RUN_BITS-1:0]   run;
    logic [tep_pkg::SPILL_BITS-1:0] spill;
    logic [tep_pkg::TIME_BITS-1:0]  stamp;
    logic [tep_pkg::TAG_BITS-1:0]   tag;
  } hit_t;

  typedef struct packed {
    logic [tep_pkg::CHAN_BITS-1:0] ch;
    logic                          pair;
    logic [tep_pkg::TAG_BITS-1:0]  lead_tag;
    logic [tep_pkg::TAG_BITS-1:0]  trail_tag;
    logic [tep_pkg::TIME_BITS-1:0] lead_time;
    logic [tep_pkg::DUR_BITS-1:0]  tot;
  } pair_res_t;

  typedef struct packed {
    row_kind_t kind;
    hit_t      hit;
    pair_res_t want;
  } row_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [tep_pkg::CHAN_BITS-1:0]  channel;
  logic [tep_pkg::TDC_BITS-1:0]   tdc;
  logic [tep_pkg::RUN_BITS-1:0]   run_tag;
  logic [tep_pkg::SPILL_BITS-1:0] spill_tag;
  logic [tep_pkg::TIME_BITS-1:0]  hit_time;
  logic [tep_pkg::TAG_BITS-1:0]   hit_tag;
  logic                           out_valid;
  logic                           out_stall;
  logic [tep_pkg::CHAN_BITS-1:0]  out_channel;
  logic                           out_pair;
  logic [tep_pkg::TAG_BITS-1:0]   leading_tag;
  logic [tep_pkg::TAG_BITS-1:0]   trailing_tag;
  logic [tep_pkg::TIME_BITS-1:0]  leading_time;
  logic [tep_pkg::DUR_BITS-1:0]   time_over_threshold;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tep_pkg::ADDR_BITS-1:0]  paddr;
  logic [tep_pkg::DATA_BITS-1:0]  pwdata;
  logic [tep_pkg::DATA_BITS-1:0]  prdata;
  logic                           pready;

  tot_edge_pairing i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .channel(channel), .tdc(tdc), .run_tag(run_tag), .spill_tag(spill_tag),
    .hit_time(hit_time), .hit_tag(hit_tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel(out_channel), .out_pair(out_pair),
    .leading_tag(leading_tag), .trailing_tag(trailing_tag),
    .leading_time(leading_time), .time_over_threshold(time_over_threshold),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // pairing model state
  logic [tep_pkg::DUR_BITS-1:0]   max_dur;
  logic                           lead_seen  [tep_pkg::SLOTS];
  logic [tep_pkg::TIME_BITS-1:0]  lead_stamp [tep_pkg::SLOTS];
  logic [tep_pkg::TAG_BITS-1:0]   lead_id    [tep_pkg::SLOTS];
  logic [tep_pkg::GROUP_BITS-1:0] lead_grp   [tep_pkg::SLOTS];

  pair_res_t pairs_due[$];
  row_t      stim_rows[$];
  row_kind_t row_kind;
  pair_res_t row_want;
  int        mismatches;
  int        gap_pct;
  int        stall_pct;
  int        stall_left;
  int unsigned cycles;

  // stimulus bookkeeping
  logic [tep_pkg::TIME_BITS-1:0]  gen_stamp [tep_pkg::SLOTS];
  logic [tep_pkg::GROUP_BITS-1:0] gen_grp   [tep_pkg::SLOTS];
  logic [tep_pkg::GROUP_BITS-1:0] grp_pool  [4];
  logic [tep_pkg::SLOT_BITS-1:0]  last_slot;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic bit pair_edges(input hit_t h, output pair_res_t r);
    logic [tep_pkg::SLOT_BITS-1:0]  slot;
    logic [tep_pkg::GROUP_BITS-1:0] grp;
    logic [tep_pkg::TIME_BITS-1:0]  dt;
    r = '0;
    if (int'(h.ch) >= tep_pkg::CHANNEL_COUNT) return 1'b0;
    slot = {h.ch, h.code[tep_pkg::TDC_PAIR_BIT]};
    grp = {h.run, h.spill};
    if (!h.code[tep_pkg::TDC_EDGE_BIT]) begin
      lead_seen[slot] = 1'b1;
      lead_stamp[slot] = h.stamp;
      lead_id[slot] = h.tag;
      lead_grp[slot] = grp;
      return 1'b0;
    end
    if (!lead_seen[slot] || lead_grp[slot] != grp) return 1'b0;
    lead_seen[slot] = 1'b0;
    if (h.stamp <= lead_stamp[slot]) return 1'b0;
    dt = h.stamp - lead_stamp[slot];
    if (dt > {{(tep_pkg::TIME_BITS-tep_pkg::DUR_BITS){1'b0}}, max_dur}) return 1'b0;
    r.ch = h.ch;
    r.pair = h.code[tep_pkg::TDC_PAIR_BIT];
    r.lead_tag = lead_id[slot];
    r.trail_tag = h.tag;
    r.lead_time = lead_stamp[slot];
    r.tot = dt[tep_pkg::DUR_BITS-1:0];
    return 1'b1;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) < pct) return idle_len();
    return 0;
  endfunction

  function automatic void add_row(input row_kind_t kind,
                                  input logic [tep_pkg::CHAN_BITS-1:0] ch,
                                  input logic [tep_pkg::TDC_BITS-1:0] code,
                                  input logic [tep_pkg::RUN_BITS-1:0] run,
                                  input logic [tep_pkg::SPILL_BITS-1:0] spill,
                                  input logic [tep_pkg::TIME_BITS-1:0] stamp,
                                  input logic [tep_pkg::TAG_BITS-1:0] tag,
                                  input logic [tep_pkg::TAG_BITS-1:0] ltag,
                                  input logic [tep_pkg::TIME_BITS-1:0] ltime,
                                  input logic [tep_pkg::DUR_BITS-1:0] tot);
    row_t r;
    r.kind = kind;
    r.hit = {ch, code, run, spill, stamp, tag};
    r.want = {ch, code[tep_pkg::TDC_PAIR_BIT], ltag, tag, ltime, tot};
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  task automatic report_pair(input string why, input pair_res_t want, input pair_res_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected ch %0d pair %0d lead %h trail %h time %h tot %h, ",
               why, want.ch, want.pair, want.lead_tag, want.trail_tag, want.lead_time,
               want.tot, "got ch %0d pair %0d lead %h trail %h time %h tot %h",
               seen.ch, seen.pair, seen.lead_tag, seen.trail_tag, seen.lead_time,
               seen.tot);
  endtask

  always @(posedge clk) begin
    hit_t      h;
    pair_res_t r;
    pair_res_t seen;
    pair_res_t want;
    bit        got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        h = {channel, tdc, run_tag, spill_tag, hit_time, hit_tag};
        got = pair_edges(h, r);
        if (row_kind == ROW_NONE) begin
          got = 1'b0;
        end else if (row_kind == ROW_RESULT) begin
          got = 1'b1;
          r = row_want;
        end
        if (got) pairs_due.insert(pairs_due.size(), r);
      end
      if (out_valid && !out_stall) begin
        seen = {out_channel, out_pair, leading_tag, trailing_tag, leading_time,
                time_over_threshold};
        if (pairs_due.size() == 0) begin
          report_pair("unexpected transaction", '0, seen);
        end else begin
          want = pairs_due.pop_front();
          if (seen.ch !== want.ch || seen.pair !== want.pair ||
              seen.lead_tag !== want.lead_tag || seen.trail_tag !== want.trail_tag ||
              seen.lead_time !== want.lead_time || seen.tot !== want.tot)
            report_pair("pair mismatch", want, seen);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left <= idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("[tot_edge_pairing] ERROR");
      $finish;
    end
  end

  task automatic apb_xfer(input bit wr, input logic [tep_pkg::ADDR_BITS-1:0] addr,
                          input logic [tep_pkg::DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr && addr == MAX_DUR_ADDR) max_dur = data[tep_pkg::DUR_BITS-1:0];
    if (!wr && addr == MAX_DUR_ADDR && prdata[tep_pkg::DUR_BITS-1:0] !== max_dur) begin
      mismatches++;
      if (mismatches <= 10)
        $display("max_duration readback: expected %h, got %h", max_dur, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [tep_pkg::ADDR_BITS-1:0] addr,
                         input logic [tep_pkg::DATA_BITS-1:0] data);
    apb_xfer(1'b1, addr, data);
    apb_xfer(1'b0, MAX_DUR_ADDR, '0);
  endtask

  task automatic send_hit(input hit_t h, input row_kind_t kind, input pair_res_t want);
    int gap;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_kind = kind;
    row_want = want;
    channel <= h.ch;
    tdc <= h.code;
    run_tag <= h.run;
    spill_tag <= h.spill;
    hit_time <= h.stamp;
    hit_tag <= h.tag;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic make_hit(output hit_t h);
    int                             pick;
    logic [tep_pkg::SLOT_BITS-1:0]  slot;
    logic [tep_pkg::TIME_BITS-1:0]  base;
    h.ch = tep_pkg::CHAN_BITS'($urandom);
    h.code = tep_pkg::TDC_BITS'($urandom);
    h.run = tep_pkg::RUN_BITS'($urandom);
    h.spill = tep_pkg::SPILL_BITS'($urandom);
    h.stamp = tep_pkg::TIME_BITS'({$urandom, $urandom});
    h.tag = tep_pkg::TAG_BITS'($urandom);
    pick = $urandom_range(99);
    if (pick < 15) return;
    if (pick < 55) begin
      slot = tep_pkg::SLOT_BITS'($urandom);
      h.ch = slot[tep_pkg::SLOT_BITS-1:1];
      h.code = slot[0] ? TDC_LEAD1 : TDC_LEAD0;
      if ($urandom_range(9) < 7) {h.run, h.spill} = grp_pool[$urandom_range(3)];
      if ($urandom_range(1) == 0) h.stamp = tep_pkg::TIME_BITS'($urandom_range(1000000));
      gen_stamp[slot] = h.stamp;
      gen_grp[slot] = {h.run, h.spill};
      last_slot = slot;
      return;
    end
    slot = ($urandom_range(2) != 0) ? last_slot : tep_pkg::SLOT_BITS'($urandom);
    h.ch = slot[tep_pkg::SLOT_BITS-1:1];
    h.code = slot[0] ? TDC_TRAIL1 : TDC_TRAIL0;
    {h.run, h.spill} = ($urandom_range(9) != 0) ? gen_grp[slot] : grp_pool[$urandom_range(3)];
    base = gen_stamp[slot];
    case ($urandom_range(9))
      0, 1, 2: h.stamp = base + tep_pkg::TIME_BITS'($urandom_range(1,
                                  (max_dur < 2000) ? max_dur : 2000));
      3, 4, 5: h.stamp = base + tep_pkg::TIME_BITS'($urandom_range(1, max_dur));
      6: h.stamp = base + tep_pkg::TIME_BITS'(max_dur);
      7: h.stamp = base + tep_pkg::TIME_BITS'(max_dur) + 1'b1;
      8: h.stamp = base;
      default: h.stamp = base - tep_pkg::TIME_BITS'($urandom_range(1, 5000));
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    hit_t                          h;
    row_t                          r;
    logic [tep_pkg::DATA_BITS-1:0] cfg;
    rst = 1'b1;
    in_valid = 1'b0;
    channel = '0;
    tdc = '0;
    run_tag = '0;
    spill_tag = '0;
    hit_time = '0;
    hit_tag = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycles = 0;
    stall_left = 0;
    stall_pct = 0;
    gap_pct = 0;
    row_kind = ROW_PREDICT;
    row_want = '0;
    last_slot = '0;
    max_dur = tep_pkg::MAX_DURATION_RESET;
    for (int i = 0; i < tep_pkg::SLOTS; i++) begin
      lead_seen[i] = 1'b0;
      lead_stamp[i] = '0;
      lead_id[i] = '0;
      lead_grp[i] = '0;
      gen_stamp[i] = '0;
      gen_grp[i] = '0;
    end

    add_row(ROW_NONE,   0,  TDC_TRAIL0, 0, 0, 10, 1, 0, 0, 0);
    add_row(ROW_NONE,   0,  TDC_LEAD0,  0, 0, 1000, 2, 0, 0, 0);
    add_row(ROW_RESULT, 0,  TDC_TRAIL0, 0, 0, 1001, 3, 2, 1000, 1);
    add_row(ROW_NONE,   0,  TDC_TRAIL0, 0, 0, 1002, 4, 0, 0, 0);
    add_row(ROW_NONE,   31, TDC_LEAD1,  8'hFF, 16'hFFFF, 48'hFFFF_FFFF_AFFF, 20'hFFFFF,
            0, 0, 0);
    add_row(ROW_RESULT, 31, TDC_TRAIL1, 8'hFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0,
            20'hFFFFF, 48'hFFFF_FFFF_AFFF, 24'd20480);
    add_row(ROW_NONE,   5,  TDC_LEAD0,  1, 2, 500, 10, 0, 0, 0);
    add_row(ROW_NONE,   5,  TDC_TRAIL0, 2, 2, 600, 11, 0, 0, 0);
    add_row(ROW_NONE,   5,  TDC_TRAIL0, 1, 3, 600, 12, 0, 0, 0);
    add_row(ROW_NONE,   5,  TDC_TRAIL1, 1, 2, 600, 13, 0, 0, 0);
    add_row(ROW_RESULT, 5,  TDC_TRAIL0, 1, 2, 600, 14, 10, 500, 100);
    add_row(ROW_NONE,   7,  TDC_LEAD0,  3, 4, 5000, 20, 0, 0, 0);
    add_row(ROW_NONE,   7,  TDC_TRAIL0, 3, 4, 5000, 21, 0, 0, 0);
    add_row(ROW_NONE,   7,  TDC_TRAIL0, 3, 4, 6000, 22, 0, 0, 0);
    add_row(ROW_NONE,   8,  TDC_LEAD1,  0, 0, 9000, 23, 0, 0, 0);
    add_row(ROW_NONE,   8,  TDC_TRAIL1, 0, 0, 8000, 24, 0, 0, 0);
    add_row(ROW_NONE,   9,  TDC_LEAD0,  0, 0, 0, 25, 0, 0, 0);
    add_row(ROW_NONE,   9,  TDC_TRAIL0, 0, 0, 20481, 26, 0, 0, 0);
    add_row(ROW_PREDICT, 10, TDC_LEAD0,  6, 7, 100, 30, 0, 0, 0);
    add_row(ROW_PREDICT, 10, TDC_LEAD0,  6, 7, 200, 31, 0, 0, 0);
    add_row(ROW_PREDICT, 10, TDC_TRAIL0, 6, 7, 250, 32, 0, 0, 0);
    add_row(ROW_PREDICT, 3,  TDC_LEAD0,  0, 0, 0, 40, 0, 0, 0);
    add_row(ROW_PREDICT, 3,  TDC_LEAD1,  0, 0, 10, 41, 0, 0, 0);
    add_row(ROW_PREDICT, 3,  TDC_TRAIL1, 0, 0, 15, 42, 0, 0, 0);
    add_row(ROW_PREDICT, 3,  TDC_TRAIL0, 0, 0, 7, 43, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    apb_xfer(1'b0, MAX_DUR_ADDR, '0);

    gap_pct = 30;
    stall_pct = 30;
    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      send_hit(r.hit, r.kind, r.want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: cfg = 32'hA5FF_FFFF;
        1: cfg = 32'h0300_0000;
        2: cfg = 32'h0000_0001;
        3: cfg = tep_pkg::DATA_BITS'($urandom_range(2, 200000));
        default: cfg = {8'($urandom), tep_pkg::MAX_DURATION_RESET};
      endcase
      if (ph == 1) set_reg(SPARE_ADDR, $urandom);
      set_reg(MAX_DUR_ADDR, cfg);
      for (int g = 0; g < 4; g++) grp_pool[g] = tep_pkg::GROUP_BITS'($urandom);
      gap_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
      stall_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
      row_kind = ROW_PREDICT;
      for (int n = 0; n < PHASE_HITS; n++) begin
        make_hit(h);
        send_hit(h, ROW_PREDICT, '0);
      end
    end

    in_valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("[tot_edge_pairing] OK");
    else $display("[tot_edge_pairing] ERROR");
    $finish;
  end

endmodule
